// ----- rtl/hsl_to_rgb_converter_core_defines.svh -----
// Assertion helpers used by the queue RTL (hsl_queue).
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define HSL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define HSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HSL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HSL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/hsl_pkg.sv -----
package hsl_pkg;

  // hue in 1/16 degree
  localparam int HueBias   = 34560;   // six turns, makes any 16-bit hue positive
  localparam int HueTurn   = 5760;
  localparam int HueSector = 960;
  localparam int HuePair   = 1920;
  // floor(u / 5760) == (u * TurnRecip) >> TurnShift for u < 2^17
  localparam int TurnRecip = 93207;
  localparam int TurnShift = 29;

  // channel numerators over 489600 = 128 * 3825
  localparam int ChHalf    = 244800;
  localparam int ChPre     = 7;
  // floor(v / 3825) == (v * ChRecip) >> ChShift for v < 2^20
  localparam longint ChRecip = 1122868;
  localparam int ChShift   = 32;

  localparam int QDepth = 4;
  localparam int QAw    = 2;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // classified pixel handed from front to back
  typedef struct packed {
    sector_t     sector;
    logic [9:0]  k;       // weight of x relative to c, in 1/960
    logic [15:0] cn;      // chroma times 65025
    logic [7:0]  l;
  } hsl_item_t;

endpackage

// ----- rtl/hsl_queue.sv -----
`include "hsl_to_rgb_converter_core_defines.svh"

module hsl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hsl_pkg::hsl_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output hsl_pkg::hsl_item_t pop_item
);
  import hsl_pkg::*;

  hsl_item_t        mem [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QAw:0]     count;

  assign full      = (count == (QAw+1)'(QDepth));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `HSL_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= (QAw+1)'(QDepth))
  `HSL_ASSERT_IMPLY(a_pop_nonempty, clk, rst, pop, count != '0)
  `HSL_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ----- rtl/hsl_front.sv -----
module hsl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        hue,
  input  logic [7:0]         saturation,
  input  logic [7:0]         lightness,
  output logic               item_valid,
  input  logic               item_full,
  output hsl_pkg::hsl_item_t item
);
  import hsl_pkg::*;

  // stage 1: turn count and chroma
  logic        f1_valid;
  logic [16:0] f1_u;
  logic [3:0]  f1_q;
  logic [15:0] f1_cn;
  logic [7:0]  f1_l;
  // stage 2: classified item
  logic        f2_valid;
  hsl_item_t   f2_item;

  logic        f1_ready;
  logic        f2_ready;

  logic [17:0] biased;
  logic [16:0] u;
  logic [33:0] turn_prod;
  logic [8:0]  two_l;
  logic [7:0]  a;
  logic [16:0] hr_full;
  logic [12:0] hr;
  logic [10:0] t;
  logic [9:0]  k;
  sector_t     sector;

  assign f2_ready = !f2_valid || !item_full;
  assign f1_ready = !f1_valid || f2_ready;
  assign in_stall = !f1_ready;

  assign item_valid = f2_valid;
  assign item       = f2_item;

  assign biased    = {{2{hue[15]}}, hue} + 18'(HueBias);
  assign u         = biased[16:0];
  assign turn_prod = 34'(u) * 34'(TurnRecip);

  always_comb begin
    two_l = {lightness, 1'b0};
    if (two_l >= 9'd255) begin
      a = 8'(9'd510 - two_l);
    end else begin
      a = two_l[7:0];
    end
  end

  always_comb begin
    hr_full = f1_u - 17'(f1_q * 17'(HueTurn));
    hr      = hr_full[12:0];
    if (hr >= 13'(5 * HueSector)) begin
      sector = SEC_MR;
    end else if (hr >= 13'(4 * HueSector)) begin
      sector = SEC_BM;
    end else if (hr >= 13'(3 * HueSector)) begin
      sector = SEC_CB;
    end else if (hr >= 13'(2 * HueSector)) begin
      sector = SEC_GC;
    end else if (hr >= 13'(HueSector)) begin
      sector = SEC_YG;
    end else begin
      sector = SEC_RY;
    end
    // position inside the current 120-degree pair
    if (hr >= 13'(2 * HuePair)) begin
      t = 11'(hr - 13'(2 * HuePair));
    end else if (hr >= 13'(HuePair)) begin
      t = 11'(hr - 13'(HuePair));
    end else begin
      t = hr[10:0];
    end
    if (t < 11'(HueSector)) begin
      k = t[9:0];
    end else begin
      k = 10'(11'(HuePair) - t);
    end
  end

  always_ff @(posedge clk) begin
    if (f1_ready) begin
      f1_u  <= u;
      f1_q  <= turn_prod[TurnShift +: 4];
      f1_cn <= 16'(a) * 16'(saturation);
      f1_l  <= lightness;
    end
    if (f2_ready) begin
      f2_item.sector <= sector;
      f2_item.k      <= k;
      f2_item.cn     <= f1_cn;
      f2_item.l      <= f1_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_ready) begin
        f1_valid <= in_valid;
      end
      if (f2_ready) begin
        f2_valid <= f1_valid;
      end
    end
  end

endmodule

// ----- rtl/hsl_back.sv -----
module hsl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_take,
  input  hsl_pkg::hsl_item_t item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);
  import hsl_pkg::*;

  // stage 1: scaled lightness +/- chroma, chroma times weight
  logic        b1_valid;
  sector_t     b1_sector;
  logic [16:0] b1_hi;
  logic [16:0] b1_lo;
  logic [25:0] b1_ck;
  // stage 2: numerators with rounding half, pre-shifted
  logic        b2_valid;
  sector_t     b2_sector;
  logic [19:0] b2_hi;
  logic [19:0] b2_lo;
  logic [19:0] b2_mid;
  // stage 3: quotients
  logic        b3_valid;
  sector_t     b3_sector;
  logic [8:0]  b3_hi;
  logic [8:0]  b3_lo;
  logic [8:0]  b3_mid;
  // output register
  logic        o_valid;

  logic o_ready;
  logic b3_ready;
  logic b2_ready;
  logic b1_ready;

  logic [16:0] l510;
  logic [27:0] hi_n;
  logic [27:0] lo_n;
  logic [27:0] mid_n;
  logic [40:0] hi_p;
  logic [40:0] lo_p;
  logic [40:0] mid_p;
  logic [7:0]  hi_c;
  logic [7:0]  lo_c;
  logic [7:0]  mid_c;

  assign o_ready   = !o_valid || !out_stall;
  assign b3_ready  = !b3_valid || o_ready;
  assign b2_ready  = !b2_valid || b3_ready;
  assign b1_ready  = !b1_valid || b2_ready;
  assign item_take = item_valid && b1_ready;
  assign out_valid = o_valid;

  assign l510 = 17'(item.l) * 17'd510;

  assign hi_n  = 28'(b1_hi) * 28'(HueSector) + 28'(ChHalf);
  assign lo_n  = 28'(b1_lo) * 28'(HueSector) + 28'(ChHalf);
  assign mid_n = 28'(b1_lo) * 28'(HueSector) + {1'b0, b1_ck, 1'b0} + 28'(ChHalf);

  assign hi_p  = 41'(b2_hi) * 41'(ChRecip);
  assign lo_p  = 41'(b2_lo) * 41'(ChRecip);
  assign mid_p = 41'(b2_mid) * 41'(ChRecip);

  // saturate to 0..255
  assign hi_c  = b3_hi[8] ? 8'hFF : b3_hi[7:0];
  assign lo_c  = b3_lo[8] ? 8'hFF : b3_lo[7:0];
  assign mid_c = b3_mid[8] ? 8'hFF : b3_mid[7:0];

  always_ff @(posedge clk) begin
    if (b1_ready) begin
      b1_sector <= item.sector;
      b1_hi     <= l510 + 17'(item.cn);
      b1_lo     <= l510 - 17'(item.cn);
      b1_ck     <= 26'(item.cn) * 26'(item.k);
    end
    if (b2_ready) begin
      b2_sector <= b1_sector;
      b2_hi     <= hi_n[26:ChPre];
      b2_lo     <= lo_n[26:ChPre];
      b2_mid    <= mid_n[26:ChPre];
    end
    if (b3_ready) begin
      b3_sector <= b2_sector;
      b3_hi     <= hi_p[ChShift +: 9];
      b3_lo     <= lo_p[ChShift +: 9];
      b3_mid    <= mid_p[ChShift +: 9];
    end
    if (o_ready) begin
      case (b3_sector)
        SEC_RY: begin
          red <= hi_c;  green <= mid_c; blue <= lo_c;
        end
        SEC_YG: begin
          red <= mid_c; green <= hi_c;  blue <= lo_c;
        end
        SEC_GC: begin
          red <= lo_c;  green <= hi_c;  blue <= mid_c;
        end
        SEC_CB: begin
          red <= lo_c;  green <= mid_c; blue <= hi_c;
        end
        SEC_BM: begin
          red <= mid_c; green <= lo_c;  blue <= hi_c;
        end
        default: begin
          red <= hi_c;  green <= lo_c;  blue <= mid_c;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid <= item_valid;
      end
      if (b2_ready) begin
        b2_valid <= b1_valid;
      end
      if (b3_ready) begin
        b3_valid <= b2_valid;
      end
      if (o_ready) begin
        o_valid <= b3_valid;
      end
    end
  end

endmodule

// ----- rtl/hsl_to_rgb_converter_core.sv -----
// Channel  Handshake             Fields
// in       in_valid / in_stall   hue[15:0] signed, saturation[7:0], lightness[7:0]
// out      out_valid / out_stall red[7:0], green[7:0], blue[7:0]
//
// One pixel per clock sustained while out_stall is low. Path with no stalls:
// 2 front stages, 1 queue slot, 4 back stages incl. output register.
// Front reduces hue and classifies the sector; back does the channel math
// and the rounding divides by reciprocal multiply.
// A 4-entry queue separates the two, so front keeps taking pixels while
// out_stall holds the back, until the queue fills. Reset clears all valids and the queue.
module hsl_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  lightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import hsl_pkg::*;

  logic      front_valid;
  logic      q_full;
  hsl_item_t front_item;
  logic      q_push;
  logic      q_not_empty;
  logic      q_pop;
  hsl_item_t q_item;

  assign q_push = front_valid && !q_full;

  hsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .item_valid (front_valid),
    .item_full  (q_full),
    .item       (front_item)
  );

  hsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  hsl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .item_take  (q_pop),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

endmodule
